@@ hdl/mras_pkg.sv @@
// Shared codes, command set and status bundle for the multilevel round-robin aging scheduler.
package mras_pkg;

  // Action codes
  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_KEY  = 2'd2;

  // Task status codes
  localparam logic [1:0] ST_READY  = 2'd0;
  localparam logic [1:0] ST_KBWAIT = 2'd1;
  localparam logic [1:0] ST_TERM   = 2'd2;

  // Priority code that marks an invalid request
  localparam logic [1:0] PRIO_BAD = 2'd3;

  // Configuration register indexes
  localparam logic CFG_MED = 1'b0;
  localparam logic CFG_LOW = 1'b1;

  // Wait counter limits and reset thresholds
  localparam logic [3:0] WAIT_MAX  = 4'd15;
  localparam logic [3:0] MED_RESET = 4'd3;
  localparam logic [3:0] LOW_RESET = 4'd6;

  // Commands from the sequencer to the datapath
  typedef enum logic [4:0] {
    C_NONE,
    C_LOAD,
    C_BAD,
    C_ENQ,
    C_KBSET,
    C_KB,
    C_UN_SETQ,
    C_WS_RD,
    C_WS_INIT,
    C_WE_EXEC,
    C_TERM,
    C_PUSH_WR,
    C_SCAN_INIT,
    C_SCAN,
    C_POP_RD,
    C_POP_HEAD,
    C_POP_FIN,
    C_RF_KB,
    C_RF_HOME,
    C_RF_TERM,
    C_AGE_INIT,
    C_AGE_NEXT,
    C_OUT
  } mras_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic [1:0] act;
    logic [1:0] status;
    logic       bad_prio;
    logic       tid_ok;
    logic       tid_queued;
    logic       tid_running;
    logic       kb_flag;
    logic       kb_ne;
    logic       found;
    logic       scan_last;
    logic       cur_valid;
    logic       qsel_ne;
    logic       match;
    logic       at_end;
    logic       age_mode;
    logic       age_last;
    logic       out_free;
  } mras_stat_t;

endpackage

@@ hdl/mras_if.sv @@
// Request and result channel interfaces of the scheduler.
interface mras_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [5:0] task_id;
  logic [3:0] user;
  logic [1:0] prio;
  logic [1:0] status;

  modport source(output valid, action, task_id, user, prio, status, input ready);
  modport sink(input valid, action, task_id, user, prio, status, output ready);
endinterface

interface mras_rsp_if;
  logic       valid;
  logic       ready;
  logic       switched;
  logic [5:0] running_task;
  logic       running_valid;
  logic       bad_prio;
  logic       terminated;

  modport source(output valid, switched, running_task, running_valid, bad_prio, terminated,
                 input ready);
  modport sink(input valid, switched, running_task, running_valid, bad_prio, terminated,
               output ready);
endinterface

@@ hdl/mras_datapath.sv @@
// Datapath of the scheduler: task and queue memories, list walker, scan and output register.
module mras_datapath
  import mras_pkg::*;
#(
  parameter int MAX_TASKS = 64,
  parameter int NUM_USERS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  mras_cmd_t  cmd,
  output mras_stat_t st,
  input  logic [1:0] action,
  input  logic [5:0] task_id,
  input  logic [3:0] user,
  input  logic [1:0] prio,
  input  logic [1:0] status,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data,
  input  logic       out_ready,
  output logic       out_valid,
  output logic       switched,
  output logic [5:0] running_task,
  output logic       running_valid,
  output logic       bad_prio,
  output logic       terminated
);

  localparam int TW = $clog2(MAX_TASKS);
  localparam int NQ = 3 * NUM_USERS + 1;
  localparam int QW = $clog2(NQ);
  localparam int UW = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
  localparam logic [QW-1:0] KBQ = QW'(3 * NUM_USERS);
  localparam logic [UW-1:0] ULAST = UW'(NUM_USERS - 1);

  // user slot modulo the number of users, as a small table
  function automatic logic [UW-1:0] umod(input logic [3:0] v);
    logic [UW-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v == 4'(i)) r = UW'(i % NUM_USERS);
    end
    return r;
  endfunction

  function automatic logic [UW-1:0] unext(input logic [UW-1:0] v);
    return (v == ULAST) ? '0 : v + 1'b1;
  endfunction

  // memories
  logic [QW-1:0] thome [MAX_TASKS];
  logic [QW-1:0] tqnum [MAX_TASKS];
  logic [TW-1:0] tnext [MAX_TASKS];
  logic [3:0]    twait [MAX_TASKS];
  logic [TW-1:0] qhead [NQ];
  logic [TW-1:0] qtail [NQ];

  logic [QW-1:0] rd_home, rd_qnum;
  logic [TW-1:0] rd_next, rd_head, rd_tail;
  logic [3:0]    rd_wait;

  // flags with reset
  logic [MAX_TASKS-1:0] tq, twv;
  logic [NQ-1:0]        qne;
  logic                 cur_valid, kb, ov;
  logic [UW-1:0]        rot;
  logic [3:0]           med_w, low_w;

  // working registers
  logic [1:0]    act_r, prio_r, stat_r;
  logic [TW-1:0] tidx, cur_task, cur, prv, otail, ptask, pt;
  logic          tid_ok, first, phase_med, age_mode;
  logic [QW-1:0] home_r, qsel, pq, qbase;
  logic [UW-1:0] sidx, scnt, ucnt;
  logic          res_sw, res_bad, res_term;

  // combinational helpers
  logic [QW-1:0] rt_addr, sbase, slvl;
  logic          user_any;
  logic [3:0]    w_cur, w_inc, limit;
  logic          match, at_end;

  assign rt_addr  = (cmd == C_WS_RD || cmd == C_POP_RD) ? qsel : pq;
  assign sbase    = QW'(QW'(sidx) * QW'(3));
  assign user_any = qne[sbase] | qne[sbase + QW'(1)] | qne[sbase + QW'(2)];
  assign slvl     = qne[sbase + QW'(2)] ? QW'(2) : (qne[sbase + QW'(1)] ? QW'(1) : QW'(0));
  assign w_cur    = twv[cur] ? rd_wait : 4'd0;
  assign w_inc    = (w_cur == WAIT_MAX) ? WAIT_MAX : w_cur + 4'd1;
  assign limit    = phase_med ? med_w : low_w;
  assign match    = age_mode ? (w_inc >= limit) : (cur == tidx);
  assign at_end   = (cur == otail);

  // status to the sequencer
  always_comb begin
    st.act         = act_r;
    st.status      = stat_r;
    st.bad_prio    = (prio_r == PRIO_BAD);
    st.tid_ok      = tid_ok;
    st.tid_queued  = tq[tidx];
    st.tid_running = cur_valid && (cur_task == tidx);
    st.kb_flag     = kb;
    st.kb_ne       = qne[KBQ];
    st.found       = user_any;
    st.scan_last   = (scnt == ULAST);
    st.cur_valid   = cur_valid;
    st.qsel_ne     = qne[qsel];
    st.match       = match;
    st.at_end      = at_end;
    st.age_mode    = age_mode;
    st.age_last    = !phase_med && (ucnt == ULAST);
    st.out_free    = !ov || out_ready;
  end

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd == C_ENQ) thome[tidx] <= home_r;
    if (cmd == C_PUSH_WR) tqnum[pt] <= pq;
    if (cmd == C_PUSH_WR && qne[pq]) tnext[rd_tail] <= pt;
    else if (cmd == C_WE_EXEC && match && !first) tnext[prv] <= rd_next;
    if (cmd == C_WE_EXEC && age_mode) twait[cur] <= w_inc;
    if (cmd == C_PUSH_WR && !qne[pq]) qhead[pq] <= pt;
    else if (cmd == C_WE_EXEC && match && first && !at_end) qhead[qsel] <= rd_next;
    else if (cmd == C_POP_FIN && !at_end) qhead[qsel] <= rd_next;
    if (cmd == C_PUSH_WR) qtail[pq] <= pt;
    else if (cmd == C_WE_EXEC && match && !first && at_end) qtail[qsel] <= prv;
    rd_home <= thome[ptask];
    rd_qnum <= tqnum[tidx];
    rd_next <= tnext[cur];
    rd_wait <= twait[cur];
    rd_head <= qhead[qsel];
    rd_tail <= qtail[rt_addr];
  end

  // control flags, configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tq        <= '0;
      twv       <= '0;
      qne       <= '0;
      cur_valid <= 1'b0;
      kb        <= 1'b0;
      ov        <= 1'b0;
      rot       <= '0;
      med_w     <= MED_RESET;
      low_w     <= LOW_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MED) med_w <= cfg_data;
        else if (cfg_index == CFG_LOW) low_w <= cfg_data;
      end
      if (cmd == C_OUT) ov <= 1'b1;
      else if (out_ready) ov <= 1'b0;
      case (cmd)
        C_KBSET: kb <= 1'b1;
        C_KB: kb <= 1'b0;
        C_SCAN_INIT: rot <= unext(rot);
        C_SCAN: if (user_any) rot <= unext(sidx);
        C_PUSH_WR: begin
          qne[pq] <= 1'b1;
          tq[pt]  <= 1'b1;
        end
        C_WE_EXEC: begin
          if (match) begin
            tq[cur] <= 1'b0;
            if (first && at_end) qne[qsel] <= 1'b0;
          end
          if (age_mode) twv[cur] <= 1'b1;
        end
        C_POP_FIN: begin
          tq[cur]   <= 1'b0;
          twv[cur]  <= 1'b0;
          cur_valid <= 1'b1;
          if (at_end) qne[qsel] <= 1'b0;
        end
        C_RF_TERM: twv[ptask] <= 1'b0;
        C_TERM: begin
          twv[tidx] <= 1'b0;
          if (cur_valid && cur_task == tidx) cur_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd)
      C_LOAD: begin
        act_r    <= action;
        prio_r   <= prio;
        stat_r   <= status;
        tidx     <= TW'(task_id);
        tid_ok   <= ({26'd0, task_id} < 32'(MAX_TASKS));
        home_r   <= QW'(QW'(umod(user)) * QW'(3)) + QW'(prio);
        res_sw   <= 1'b0;
        res_bad  <= 1'b0;
        res_term <= 1'b0;
      end
      C_BAD: res_bad <= 1'b1;
      C_ENQ: begin
        pq <= (stat_r == ST_READY) ? home_r : KBQ;
        pt <= tidx;
      end
      C_UN_SETQ: begin
        qsel     <= rd_qnum;
        age_mode <= 1'b0;
      end
      C_WS_INIT: begin
        cur   <= rd_head;
        otail <= rd_tail;
        first <= 1'b1;
      end
      C_WE_EXEC: begin
        if (match) begin
          pt <= cur;
        end else begin
          prv   <= cur;
          first <= 1'b0;
        end
        cur <= rd_next;
      end
      C_TERM: res_term <= 1'b1;
      C_KB: qsel <= KBQ;
      C_SCAN_INIT: begin
        sidx <= rot;
        scnt <= '0;
      end
      C_SCAN: begin
        if (user_any) begin
          qsel <= sbase + slvl;
        end else begin
          sidx <= unext(sidx);
          scnt <= scnt + 1'b1;
        end
      end
      C_POP_HEAD: begin
        cur   <= rd_head;
        otail <= rd_tail;
      end
      C_POP_FIN: begin
        ptask    <= cur_task;
        cur_task <= cur;
        res_sw   <= 1'b1;
      end
      C_RF_KB: begin
        pq <= KBQ;
        pt <= ptask;
      end
      C_RF_HOME: begin
        pq <= rd_home;
        pt <= ptask;
      end
      C_RF_TERM: res_term <= 1'b1;
      C_AGE_INIT: begin
        qbase     <= '0;
        ucnt      <= '0;
        phase_med <= 1'b1;
        qsel      <= QW'(1);
        pq        <= QW'(2);
        age_mode  <= 1'b1;
      end
      C_AGE_NEXT: begin
        if (phase_med) begin
          phase_med <= 1'b0;
          qsel      <= qbase;
          pq        <= qbase + QW'(1);
        end else begin
          phase_med <= 1'b1;
          qbase     <= qbase + QW'(3);
          qsel      <= qbase + QW'(4);
          pq        <= qbase + QW'(5);
          ucnt      <= ucnt + 1'b1;
        end
      end
      C_OUT: begin
        switched      <= res_sw;
        running_task  <= cur_valid ? 6'(cur_task) : 6'd0;
        running_valid <= cur_valid;
        bad_prio      <= res_bad;
        terminated    <= res_term;
      end
      default: ;
    endcase
  end

  assign out_valid = ov;

endmodule

@@ hdl/mras_ctrl.sv @@
// Sequencer of the scheduler: steps enqueue, terminate, dispatch and aging through the datapath.
module mras_ctrl
  import mras_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  mras_stat_t st,
  output mras_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_PUSH0, S_PUSH1, S_UN0, S_WS0, S_WS1, S_WE0, S_WE1, S_TERM,
    S_SCAN, S_POP0, S_POP1, S_POP2, S_POP3, S_RF0, S_RF1, S_AGE_INIT, S_AGE_Q,
    S_AGE_NEXT, S_DONE
  } state_t;

  state_t state, state_next, ret, ret_next;

  assign in_ready = (state == S_IDLE);

  // next state, return point and command
  always_comb begin
    cmd        = C_NONE;
    state_next = state;
    ret_next   = ret;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = C_LOAD;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        case (st.act)
          ACT_ENQ: begin
            if (st.bad_prio) begin
              cmd        = C_BAD;
              state_next = S_DONE;
            end else if (!st.tid_ok) begin
              state_next = S_DONE;
            end else if (st.status == ST_TERM) begin
              state_next = st.tid_queued ? S_UN0 : S_TERM;
            end else if (st.status inside {ST_READY, ST_KBWAIT} && !st.tid_queued &&
                         !st.tid_running) begin
              cmd        = C_ENQ;
              state_next = S_PUSH0;
              ret_next   = S_DONE;
            end else begin
              state_next = S_DONE;
            end
          end
          ACT_KEY: begin
            cmd        = C_KBSET;
            state_next = S_DONE;
          end
          ACT_TICK: begin
            if (st.kb_flag) begin
              cmd        = C_KB;
              state_next = st.kb_ne ? S_POP0 : S_AGE_INIT;
            end else begin
              cmd        = C_SCAN_INIT;
              state_next = S_SCAN;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_PUSH0: state_next = S_PUSH1;
      S_PUSH1: begin
        cmd        = C_PUSH_WR;
        state_next = ret;
      end
      S_UN0: begin
        cmd        = C_UN_SETQ;
        state_next = S_WS0;
      end
      S_WS0: begin
        cmd        = C_WS_RD;
        state_next = S_WS1;
      end
      S_WS1: begin
        cmd        = C_WS_INIT;
        state_next = S_WE0;
      end
      S_WE0: state_next = S_WE1;
      S_WE1: begin
        cmd = C_WE_EXEC;
        if (st.age_mode) begin
          if (st.match) begin
            state_next = S_PUSH1;
            ret_next   = st.at_end ? S_AGE_NEXT : S_WE0;
          end else begin
            state_next = st.at_end ? S_AGE_NEXT : S_WE0;
          end
        end else begin
          state_next = st.match ? S_TERM : S_WE0;
        end
      end
      S_TERM: begin
        cmd        = C_TERM;
        state_next = S_DONE;
      end
      S_SCAN: begin
        cmd = C_SCAN;
        if (st.found) state_next = S_POP0;
        else if (st.scan_last) state_next = S_AGE_INIT;
      end
      S_POP0: begin
        cmd        = C_POP_RD;
        state_next = S_POP1;
      end
      S_POP1: begin
        cmd        = C_POP_HEAD;
        state_next = S_POP2;
      end
      S_POP2: state_next = S_POP3;
      S_POP3: begin
        cmd        = C_POP_FIN;
        state_next = st.cur_valid ? S_RF0 : S_AGE_INIT;
      end
      S_RF0: begin
        case (st.status)
          ST_READY: state_next = S_RF1;
          ST_KBWAIT: begin
            cmd        = C_RF_KB;
            state_next = S_PUSH0;
            ret_next   = S_AGE_INIT;
          end
          ST_TERM: begin
            cmd        = C_RF_TERM;
            state_next = S_AGE_INIT;
          end
          default: state_next = S_AGE_INIT;
        endcase
      end
      S_RF1: begin
        cmd        = C_RF_HOME;
        state_next = S_PUSH0;
        ret_next   = S_AGE_INIT;
      end
      S_AGE_INIT: begin
        cmd        = C_AGE_INIT;
        state_next = S_AGE_Q;
      end
      S_AGE_Q: state_next = st.qsel_ne ? S_WS0 : S_AGE_NEXT;
      S_AGE_NEXT: begin
        cmd        = C_AGE_NEXT;
        state_next = st.age_last ? S_DONE : S_AGE_Q;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd        = C_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // hold state and return point
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_DONE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

endmodule

@@ hdl/multilevel_round_robin_aging_scheduler.sv @@
// Top level of the multilevel round-robin aging scheduler.
// Usage: requests arrive on the req channel (valid/ready); each accepted request gives
// exactly one result transfer on the rsp channel. A request is an enqueue (ready, keyboard
// wait or terminate), a dispatch tick, or a keyboard event. Thresholds are written on the
// cfg port (index 0 medium, index 1 low) while the block is idle.
// A dispatch tick takes the keyboard queue after a key event, else scans the users; it then
// pops the chosen task, re-files the old one, and walks the medium and low queues of every
// user, aging each queued task and promoting those that reach the threshold. The walk over
// the linked lists, one entry at a time on the single next-link memory port, sets the tick
// time. A terminate of a queued task also walks its list to unlink it.
// One request is worked on at a time; req.ready is high only when the sequencer is idle.
// A finished result sits in an output register; the next request is taken while it waits,
// and the block holds at the end of that request until rsp is free.
// Reset (synchronous, active high) empties all queues, clears wait counts, the keyboard
// flag and rotation index, leaves no task running and reloads the thresholds 3 and 6.
module multilevel_round_robin_aging_scheduler
  import mras_pkg::*;
#(
  parameter int MAX_TASKS = 64,
  parameter int NUM_USERS = 16
) (
  input  logic       clk,
  input  logic       rst,
  mras_req_if.sink   req,
  mras_rsp_if.source rsp,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data
);

  mras_cmd_t  cmd;
  mras_stat_t st;

  // sequencer
  mras_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // queues, task store and result register
  mras_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .NUM_USERS (NUM_USERS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .action        (req.action),
    .task_id       (req.task_id),
    .user          (req.user),
    .prio          (req.prio),
    .status        (req.status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_ready     (rsp.ready),
    .out_valid     (rsp.valid),
    .switched      (rsp.switched),
    .running_task  (rsp.running_task),
    .running_valid (rsp.running_valid),
    .bad_prio      (rsp.bad_prio),
    .terminated    (rsp.terminated)
  );

endmodule

@@ bench/multilevel_round_robin_aging_scheduler_test.sv @@
// Self-checking testbench for the multilevel round-robin aging scheduler.
`timescale 1ns / 100ps

module multilevel_round_robin_aging_scheduler_test;
  import mras_pkg::*;

  localparam int NTASK = 64;
  localparam int NUSER = 16;
  localparam int KBQ = NUSER * 3;
  localparam int SETTLE = 500;

  typedef struct {
    logic [1:0] action;
    logic [5:0] task_id;
    logic [3:0] user;
    logic [1:0] prio;
    logic [1:0] status;
  } sched_req_t;

  typedef struct {
    logic       switched;
    logic [5:0] running_task;
    logic       running_valid;
    logic       bad_prio;
    logic       terminated;
  } sched_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [3:0] cfg_data = 4'd0;

  mras_req_if req();
  mras_rsp_if rsp();

  multilevel_round_robin_aging_scheduler DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  sched_req_t pending_reqs[$];
  sched_rsp_t expected_rsps[$];
  int fails = 0;
  int quiet_items = 0;

  // Scheduler state mirror
  int  tk_user[NTASK], tk_level[NTASK], tk_wait[NTASK], tk_next[NTASK], tk_qnum[NTASK];
  bit  tk_queued[NTASK];
  int  qhead[KBQ + 1], qtail[KBQ + 1], qcount[KBQ + 1];
  int  rot_idx, run_task;
  bit  kb_flag, run_valid;
  int  med_limit, low_limit;

  function automatic void clear_sched();
    for (int i = 0; i < NTASK; i++) begin
      tk_user[i] = 0; tk_level[i] = 0; tk_wait[i] = 0; tk_next[i] = 0;
      tk_qnum[i] = 0; tk_queued[i] = 0;
    end
    for (int q = 0; q <= KBQ; q++) begin
      qhead[q] = 0; qtail[q] = 0; qcount[q] = 0;
    end
    rot_idx = 0; run_task = 0; kb_flag = 0; run_valid = 0;
    med_limit = MED_RESET; low_limit = LOW_RESET;
  endfunction

  function automatic void push_task(int q, int t);
    tk_next[t] = 0;
    if (qcount[q] == 0) qhead[q] = t;
    else tk_next[qtail[q]] = t;
    qtail[q] = t;
    qcount[q]++;
    tk_queued[t] = 1;
    tk_qnum[t] = q;
  endfunction

  function automatic int pop_task(int q);
    int t;
    t = qhead[q];
    qhead[q] = tk_next[t];
    qcount[q]--;
    tk_queued[t] = 0;
    return t;
  endfunction

  function automatic void unlink_task(int t);
    int q, cur, prv, n;
    q = tk_qnum[t]; cur = qhead[q]; prv = 0; n = qcount[q];
    for (int k = 0; k < n; k++) begin
      if (cur == t) begin
        if (k == 0) qhead[q] = tk_next[cur];
        else tk_next[prv] = tk_next[cur];
        if (k + 1 == n) qtail[q] = prv;
        qcount[q]--;
        break;
      end
      prv = cur;
      cur = tk_next[cur];
    end
    tk_queued[t] = 0;
  endfunction

  // File a task by status; returns 1 when the slot was freed
  function automatic bit file_task(int t, logic [1:0] st);
    if (st == ST_READY) begin
      push_task(tk_user[t] * 3 + tk_level[t], t);
    end else if (st == ST_KBWAIT) begin
      push_task(KBQ, t);
    end else if (st == ST_TERM) begin
      if (tk_queued[t]) unlink_task(t);
      if (run_valid && run_task == t) run_valid = 0;
      tk_wait[t] = 0;
      return 1;
    end
    return 0;
  endfunction

  function automatic void age_level(int q, int up, int lim);
    int t, n, nxt;
    t = qhead[q]; n = qcount[q];
    for (int k = 0; k < n; k++) begin
      nxt = tk_next[t];
      if (tk_wait[t] < WAIT_MAX) tk_wait[t]++;
      if (tk_wait[t] >= lim) begin
        unlink_task(t);
        push_task(up, t);
      end
      t = nxt;
    end
  endfunction

  function automatic sched_rsp_t schedule_step(sched_req_t r);
    sched_rsp_t res;
    int t, nxt_task, idx, prv;
    bit found, had;
    res = '{default: 0};
    t = r.task_id;
    if (r.action == ACT_ENQ) begin
      if (r.prio == PRIO_BAD) begin
        res.bad_prio = 1;
      end else if (r.status == ST_TERM) begin
        res.terminated = file_task(t, ST_TERM);
      end else if (r.status < ST_TERM && !tk_queued[t] && !(run_valid && run_task == t)) begin
        tk_user[t] = r.user % NUSER;
        tk_level[t] = r.prio;
        void'(file_task(t, r.status));
      end
    end else if (r.action == ACT_KEY) begin
      kb_flag = 1;
    end else if (r.action == ACT_TICK) begin
      found = 0; nxt_task = 0;
      if (kb_flag) begin
        if (qcount[KBQ] != 0) begin
          nxt_task = pop_task(KBQ);
          found = 1;
        end
        kb_flag = 0;
      end else begin
        idx = rot_idx % NUSER;
        for (int k = 0; k < NUSER && !found; k++) begin
          for (int lv = 2; lv >= 0; lv--) begin
            if (qcount[idx * 3 + lv] != 0) begin
              nxt_task = pop_task(idx * 3 + lv);
              found = 1;
              break;
            end
          end
          if (!found) idx = (idx + 1) % NUSER;
        end
        rot_idx = (idx + 1) % NUSER;
      end
      if (found) begin
        had = run_valid; prv = run_task;
        run_task = nxt_task; run_valid = 1;
        tk_wait[nxt_task] = 0;
        res.switched = 1;
        if (had) res.terminated = file_task(prv, r.status);
      end
      for (int u = 0; u < NUSER; u++) begin
        age_level(u * 3 + 1, u * 3 + 2, med_limit);
        age_level(u * 3, u * 3 + 1, low_limit);
      end
    end
    res.running_valid = run_valid;
    res.running_task = run_valid ? run_task[5:0] : 6'd0;
    return res;
  endfunction

  // Gaps: mostly short, a few long, with calm stretches of none
  function automatic int pick_gap();
    int r;
    if (quiet_items > 0) begin
      quiet_items--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 2) quiet_items = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Driver: present the oldest pending item, predict on transfer
  int send_gap = 0;
  bit fire;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      fire = req.valid && req.ready;
      if (fire) begin
        expected_rsps.push_back(schedule_step(pending_reqs.pop_front()));
        send_gap = pick_gap();
      end
      if (req.valid && !fire) begin
        // hold the current item
      end else if (send_gap > 0) begin
        send_gap--;
        req.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req.valid   <= 1'b1;
        req.action  <= pending_reqs[0].action;
        req.task_id <= pending_reqs[0].task_id;
        req.user    <= pending_reqs[0].user;
        req.prio    <= pending_reqs[0].prio;
        req.status  <= pending_reqs[0].status;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Monitor: compare each result transfer with the oldest expectation
  int stall = 0;
  sched_rsp_t want;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, actual task %0d", $time, rsp.running_task);
        end else begin
          want = expected_rsps.pop_front();
          check_field("switched", want.switched, rsp.switched);
          check_field("running_task", want.running_task, rsp.running_task);
          check_field("running_valid", want.running_valid, rsp.running_valid);
          check_field("bad_prio", want.bad_prio, rsp.bad_prio);
          check_field("terminated", want.terminated, rsp.terminated);
        end
        stall = pick_gap();
      end
      if (stall > 0) begin
        stall--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic add_req(logic [1:0] a, int t, int u, int p, int s);
    sched_req_t r;
    r.action = a; r.task_id = 6'(t); r.user = 4'(u); r.prio = 2'(p); r.status = 2'(s);
    pending_reqs.push_back(r);
  endtask

  task automatic write_cfg(logic idx, logic [3:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MED) med_limit = val;
    else med_limit = med_limit;
    if (idx == CFG_LOW) low_limit = val;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req.valid) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random mix: mostly ready enqueues and ticks so queues fill and age
  task automatic add_random(int n);
    int r;
    logic [1:0] st;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      st = ($urandom_range(99) < 80) ? ST_READY : 2'($urandom_range(1, 2));
      if (r < 45)      add_req(ACT_ENQ, $urandom_range(63), $urandom_range(15),
                               $urandom_range(2), ST_READY);
      else if (r < 52) add_req(ACT_ENQ, $urandom_range(63), $urandom_range(15),
                               $urandom_range(2), ST_KBWAIT);
      else if (r < 58) add_req(ACT_ENQ, $urandom_range(63), $urandom_range(15),
                               $urandom_range(2), ST_TERM);
      else if (r < 61) add_req(ACT_ENQ, $urandom_range(63), $urandom_range(15),
                               PRIO_BAD, $urandom_range(2));
      else if (r < 66) add_req(ACT_KEY, $urandom_range(63), $urandom_range(15),
                               $urandom_range(3), $urandom_range(2));
      else             add_req(ACT_TICK, $urandom_range(63), $urandom_range(15),
                               $urandom_range(3), st);
    end
  endtask

  initial begin
    req.valid = 1'b0; req.action = ACT_ENQ; req.task_id = 6'd0; req.user = 4'd0;
    req.prio = 2'd0; req.status = ST_READY; rsp.ready = 1'b0;
    clear_sched();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: every level, extremes, keyboard path, duplicates, terminate cases
    add_req(ACT_TICK, 0, 0, 0, ST_READY);
    add_req(ACT_ENQ, 0, 0, 0, ST_READY);
    add_req(ACT_ENQ, 63, 15, 2, ST_READY);
    add_req(ACT_ENQ, 21, 15, 1, ST_READY);
    add_req(ACT_ENQ, 42, 0, 2, ST_READY);
    add_req(ACT_ENQ, 42, 3, 1, ST_READY);
    add_req(ACT_ENQ, 7, 5, PRIO_BAD, ST_TERM);
    add_req(ACT_ENQ, 9, 10, 1, ST_KBWAIT);
    add_req(ACT_TICK, 0, 0, 0, ST_READY);
    add_req(ACT_ENQ, 42, 0, 2, ST_KBWAIT);
    add_req(ACT_KEY, 0, 0, 0, ST_READY);
    add_req(ACT_TICK, 0, 0, 0, ST_KBWAIT);
    add_req(ACT_KEY, 0, 0, 0, ST_READY);
    add_req(ACT_TICK, 0, 0, 0, ST_READY);
    add_req(ACT_KEY, 0, 0, 0, ST_READY);
    add_req(ACT_TICK, 0, 0, 0, ST_TERM);
    add_req(ACT_ENQ, 21, 15, 1, ST_TERM);
    add_req(ACT_ENQ, 33, 8, 0, ST_TERM);
    add_req(ACT_TICK, 63, 15, 3, ST_READY);
    add_req(ACT_TICK, 0, 0, 0, ST_READY);
    add_req(ACT_TICK, 0, 0, 0, ST_TERM);
    add_req(ACT_TICK, 0, 0, 0, ST_READY);
    drain();

    // Thresholds at the lowest, the highest, random, then back to the reset values
    write_cfg(CFG_MED, 4'd1);
    write_cfg(CFG_LOW, 4'd1);
    add_random(250);
    drain();
    write_cfg(CFG_MED, 4'd15);
    write_cfg(CFG_LOW, 4'd15);
    add_random(300);
    drain();
    write_cfg(CFG_MED, 4'($urandom_range(1, 15)));
    write_cfg(CFG_LOW, 4'($urandom_range(1, 15)));
    add_random(300);
    drain();
    write_cfg(CFG_MED, 4'd3);
    write_cfg(CFG_LOW, 4'd6);
    add_random(300);
    drain();

    if (fails == 0) begin
      $display("PASS multilevel_round_robin_aging_scheduler");
    end else begin
      $display("FAIL multilevel_round_robin_aging_scheduler");
    end
    $finish;
  end

  // Run limit
  initial begin
    #30000000;
    $display("FAIL multilevel_round_robin_aging_scheduler");
    $finish;
  end

endmodule

@@ files.f @@
hdl/mras_pkg.sv
hdl/mras_if.sv
hdl/mras_datapath.sv
hdl/mras_ctrl.sv
hdl/multilevel_round_robin_aging_scheduler.sv
bench/multilevel_round_robin_aging_scheduler_test.sv
